>>> hw/rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants for the shuffle bag index draw block.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int MAX_ITEMS_DEF = 256;

    localparam int RNG_W       = 32;
    localparam int DIV_STEP_W  = $clog2(RNG_W);
    localparam int COUNT_CFG_W = 9;
    localparam int INDEX_OUT_W = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED   = 1'd1;

    localparam logic [RNG_W-1:0] RNG_RESET = 32'd1;

    typedef struct packed {
        logic load;
        logic step;
    } rng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> hw/rtl/sbd_rng.sv
// ----------------------------------------------------------------------------
// sbd_rng
// xorshift32 generator: loads a seed (zero forced to one), steps on request.
// ----------------------------------------------------------------------------
module sbd_rng
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbd_pkg::rng_ctrl_t        ctrl,
    input  logic [sbd_pkg::RNG_W-1:0] seed,
    output logic [sbd_pkg::RNG_W-1:0] value
);

    logic [sbd_pkg::RNG_W-1:0] state_reg;
    logic [sbd_pkg::RNG_W-1:0] state_next;
    logic [sbd_pkg::RNG_W-1:0] x1;
    logic [sbd_pkg::RNG_W-1:0] x2;
    logic [sbd_pkg::RNG_W-1:0] x3;

    always_comb
    begin
        x1 = state_reg ^ (state_reg << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next = (seed == '0) ? sbd_pkg::RNG_RESET : seed;
        end
        else if (ctrl.step)
        begin
            state_next = x3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbd_pkg::RNG_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign value = state_reg;

endmodule

>>> hw/rtl/sbd_modulo.sv
// ----------------------------------------------------------------------------
// sbd_modulo
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sbd_modulo
#(
    parameter int DIV_W = sbd_pkg::COUNT_CFG_W
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sbd_pkg::RNG_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output sbd_pkg::div_status_t      status,
    output logic [DIV_W-1:0]          remainder
);

    logic [sbd_pkg::RNG_W-1:0]      shift_reg;
    logic [DIV_W-1:0]               rem_reg;
    logic [DIV_W-1:0]               div_reg;
    logic [sbd_pkg::DIV_STEP_W-1:0] step_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [DIV_W:0]                 trial;
    logic [DIV_W:0]                 diff;
    logic                           last_step;

    always_comb
    begin
        trial     = {rem_reg, shift_reg[sbd_pkg::RNG_W-1]};
        diff      = trial - {1'b0, div_reg};
        last_step = (step_reg == '1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[sbd_pkg::RNG_W-2:0], 1'b0};
            // trial < 2*divisor, so the kept value always fits DIV_W bits
            rem_reg   <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

>>> hw/rtl/sbd_bag_mem.sv
// ----------------------------------------------------------------------------
// sbd_bag_mem
// Bag entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbd_bag_mem
#(
    parameter int DEPTH = sbd_pkg::MAX_ITEMS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ADDR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/shuffle_bag_index_draw.sv
// ----------------------------------------------------------------------------
// shuffle_bag_index_draw
// Shuffle bag: serves 0..n-1 in random order, reshuffling when used up or when n changes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write item_count (index 0) and
//   rng_seed (index 1, loads the xorshift32 state at once). cfg_ready is
//   always high; write only while the block is idle.
//   A word on s_* with bit 0 set requests a draw; bit 0 clear is dropped.
//   Each draw gives one word on m_*: m_tdata the index, m_tuser the empty
//   flag (item_count zero, index reads zero).
// Draw sequence:
//   Empty bag: straight to the emit state, then m_tvalid.
//   Draw from a built bag: read state, then emit state, then m_tvalid.
//   Draw that rebuilds the bag: n fill steps, then n-1 swaps (generator
//   step, modulo, read i, read j, write i, write j), then the read; each
//   swap is dominated by the bit-serial modulo.
//   Throughput is one draw at a time; the next word is taken once the
//   result sits in the output register.
// Reset: bag marked unbuilt, item_count 0, generator state 1.
// Stall: a result waiting on m_tready holds the output register; a draw
//   finishing behind it waits before loading.
// ----------------------------------------------------------------------------
module shuffle_bag_index_draw
#(
    parameter int MAX_ITEMS = sbd_pkg::MAX_ITEMS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbd_pkg::RNG_W-1:0]     cfg_data,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] draw, [7:1] zero
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] drawn_index
    output logic [0:0]                    m_tuser    // [0] bag_empty
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (CNT_W > sbd_pkg::COUNT_CFG_W) ? CNT_W : sbd_pkg::COUNT_CFG_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_RNG  = 4'd2;
    localparam logic [3:0] S_DIVS = 4'd3;
    localparam logic [3:0] S_DIVW = 4'd4;
    localparam logic [3:0] S_RDI  = 4'd5;
    localparam logic [3:0] S_RDJ  = 4'd6;
    localparam logic [3:0] S_WRI  = 4'd7;
    localparam logic [3:0] S_WRJ  = 4'd8;
    localparam logic [3:0] S_READ = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0]                         state_reg;
    logic [sbd_pkg::COUNT_CFG_W-1:0]    item_count_reg;
    logic [CNT_W-1:0]                   n_reg;
    logic [CNT_W-1:0]                   pos_reg;
    logic [CNT_W-1:0]                   built_reg;
    logic [IDX_W-1:0]                   i_reg;
    logic [IDX_W-1:0]                   ei_reg;
    logic                               empty_reg;
    logic                               m_tvalid_reg;
    logic [7:0]                         m_tdata_reg;
    logic                               m_tuser_reg;

    logic                               s_fire;
    logic                               cfg_fire;
    logic                               out_free;
    logic [CMP_W-1:0]                   count_ext;
    logic [CNT_W-1:0]                   n_eff;
    logic [IDX_W+7:0]                   idx_ext;

    sbd_pkg::rng_ctrl_t                 rng_ctrl;
    logic [sbd_pkg::RNG_W-1:0]          rng_value;
    sbd_pkg::div_status_t               div_status;
    logic [CNT_W-1:0]                   div_rem;
    logic [IDX_W-1:0]                   j_idx;

    logic                               mem_wr_en;
    logic [IDX_W-1:0]                   mem_wr_addr;
    logic [IDX_W-1:0]                   mem_wr_data;
    logic                               mem_rd_en;
    logic [IDX_W-1:0]                   mem_rd_addr;
    logic [IDX_W-1:0]                   mem_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign count_ext = CMP_W'(item_count_reg);
    assign n_eff     = (count_ext > CMP_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS)
                                                      : CNT_W'(count_ext);
    assign j_idx     = div_rem[IDX_W-1:0];
    assign idx_ext   = {8'd0, mem_rd_data};

    assign rng_ctrl.load = cfg_fire && (cfg_index == sbd_pkg::CFG_RNG_SEED);
    assign rng_ctrl.step = (state_reg == S_RNG);

    sbd_rng u_rng
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rng_ctrl),
        .seed  (cfg_data),
        .value (rng_value)
    );

    sbd_modulo #(.DIV_W(CNT_W)) u_modulo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_DIVS),
        .dividend  (rng_value),
        .divisor   (CNT_W'(i_reg) + 1'b1),
        .status    (div_status),
        .remainder (div_rem)
    );

    sbd_bag_mem #(.DEPTH(MAX_ITEMS)) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = i_reg;
        mem_wr_data = i_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = i_reg;
        unique case (state_reg)
            S_FILL:
            begin
                mem_wr_en = 1'b1;
            end
            S_RDI:
            begin
                mem_rd_en = 1'b1;
            end
            S_RDJ:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_idx;
            end
            S_WRI:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
            end
            S_WRJ:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = j_idx;
                mem_wr_data = ei_reg;
            end
            S_READ:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_reg[IDX_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_count_reg <= '0;
            pos_reg        <= '0;
            built_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_fire && (cfg_index == sbd_pkg::CFG_ITEM_COUNT))
            begin
                item_count_reg <= cfg_data[sbd_pkg::COUNT_CFG_W-1:0];
            end
            if ((state_reg == S_EMIT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire && s_tdata[0])
                    begin
                        if (n_eff == '0)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else if ((built_reg != n_eff) || (pos_reg >= built_reg))
                        begin
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FILL:
                begin
                    if (CNT_W'(i_reg) == n_reg - 1'b1)
                    begin
                        if (i_reg == '0)
                        begin
                            pos_reg   <= '0;
                            built_reg <= n_reg;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_RNG;
                        end
                    end
                end
                S_RNG:
                begin
                    state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= S_RDI;
                    end
                end
                S_RDI:
                begin
                    state_reg <= S_RDJ;
                end
                S_RDJ:
                begin
                    state_reg <= S_WRI;
                end
                S_WRI:
                begin
                    state_reg <= S_WRJ;
                end
                S_WRJ:
                begin
                    if (i_reg == IDX_W'(1))
                    begin
                        pos_reg   <= '0;
                        built_reg <= n_reg;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_RNG;
                    end
                end
                S_READ:
                begin
                    pos_reg   <= pos_reg + 1'b1;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            n_reg     <= n_eff;
            empty_reg <= (n_eff == '0);
            i_reg     <= '0;
        end
        if (state_reg == S_FILL && CNT_W'(i_reg) != n_reg - 1'b1)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == S_RDJ)
        begin
            ei_reg <= mem_rd_data;
        end
        if (state_reg == S_WRJ)
        begin
            i_reg <= i_reg - 1'b1;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            m_tdata_reg <= empty_reg ? 8'd0 : idx_ext[7:0];
            m_tuser_reg <= empty_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_read_in_bag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (pos_reg < built_reg))
        else $error("draw position beyond built bag");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIVW))
        else $error("modulo result with no swap waiting");

    a_empty_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("empty flag with nonzero index");

    a_swap_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDJ) |-> (j_idx <= i_reg))
        else $error("swap partner above current entry");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for shuffle_bag_index_draw. Draw requests go in as
// stream words, and a local model of the bag predicts each served index. The
// model covers the Fisher-Yates refill, the xorshift32 generator, the count
// and seed registers, and the empty flag. Each result word is checked against
// the oldest prediction. The request side runs in random bursts. The result
// side stalls to its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BAG_DEPTH      = sbd_pkg::MAX_ITEMS_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_DRAWS   = 660;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [sbd_pkg::INDEX_OUT_W-1:0] index;
        logic                            empty;
    } draw_result_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_ALTERNATE} rx_pattern_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sbd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [sbd_pkg::RNG_W-1:0]       cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;   // [0] draw, [7:1] zero
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;   // [7:0] drawn_index
    logic [0:0]                      m_tuser;   // [0] bag_empty

    // bag model
    logic [sbd_pkg::INDEX_OUT_W-1:0] bag_entries [BAG_DEPTH];
    logic [sbd_pkg::COUNT_CFG_W-1:0] bag_pos;
    logic [sbd_pkg::COUNT_CFG_W-1:0] bag_built;
    logic [sbd_pkg::COUNT_CFG_W-1:0] count_reg;
    logic [sbd_pkg::RNG_W-1:0]       rng_state;

    draw_result_t           expected_draws [$];
    int                     error_count;
    int                     draws_sent;
    int                     results_seen;
    int                     empties_seen;
    int                     reg_writes;
    int                     phases_run;
    int                     hold_cycles;
    int                     burst_left;

    shuffle_bag_index_draw u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [sbd_pkg::RNG_W-1:0] xorshift32(
        input logic [sbd_pkg::RNG_W-1:0] x);
        logic [sbd_pkg::RNG_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    task automatic refill_bag(input logic [sbd_pkg::COUNT_CFG_W-1:0] n);
        int                              i;
        logic [sbd_pkg::RNG_W-1:0]       j;
        logic [sbd_pkg::INDEX_OUT_W-1:0] t;
        for (i = 0; i < n; i++)
            bag_entries[i] = i[sbd_pkg::INDEX_OUT_W-1:0];
        for (i = n - 1; i > 0; i--)
        begin
            rng_state = xorshift32(rng_state);
            j = rng_state % $unsigned(i + 1);
            t = bag_entries[i];
            bag_entries[i] = bag_entries[j];
            bag_entries[j] = t;
        end
        bag_pos   = '0;
        bag_built = n;
    endtask

    task automatic predict_draw();
        logic [sbd_pkg::COUNT_CFG_W-1:0] n;
        draw_result_t                    r;
        n = (count_reg > BAG_DEPTH) ? sbd_pkg::COUNT_CFG_W'(BAG_DEPTH) : count_reg;
        if (n == 0)
        begin
            r.index = '0;
            r.empty = 1'b1;
        end
        else
        begin
            if (bag_built != n || bag_pos >= bag_built)
                refill_bag(n);
            r.index = bag_entries[bag_pos];
            r.empty = 1'b0;
            bag_pos = bag_pos + 1'b1;
        end
        expected_draws.push_back(r);
    endtask

    task automatic new_burst();
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    endtask

    task automatic send_word(input logic draw);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, draw};
        do @(posedge clk); while (!s_tready);
        if (draw)
        begin
            predict_draw();
            draws_sent++;
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
                @(negedge clk);
            new_burst();
        end
    endtask

    // drop valid, drain all results, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [sbd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sbd_pkg::RNG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == sbd_pkg::CFG_ITEM_COUNT)
            count_reg = value[sbd_pkg::COUNT_CFG_W-1:0];
        else
            rng_state = (value == '0) ? sbd_pkg::RNG_RESET : value;
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_draws(input int n);
        repeat (n) send_word(1'b1);
    endtask

    task automatic test_empty_bag();
        send_draws(1);
        send_word(1'b0);
        send_draws(1);
    endtask

    task automatic test_first_shuffle();
        wait_idle();
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd1);
        send_draws(2);
        wait_idle();
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd4);
        send_draws(4);
    endtask

    task automatic test_zero_seed();
        wait_idle();
        write_register(sbd_pkg::CFG_RNG_SEED, 32'd0);
        // upper data bits beyond the count width are ignored
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'hFFFF_FE03);
        send_draws(4);
    endtask

    task automatic test_oversized_count();
        wait_idle();
        write_register(sbd_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF);
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd300);
        send_draws(3);
    endtask

    task automatic test_count_change();
        wait_idle();
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd5);
        send_draws(2);
        wait_idle();
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd6);
        send_draws(2);
    endtask

    task automatic test_pressure();
        wait_idle();
        write_register(sbd_pkg::CFG_RNG_SEED, $urandom);
        write_register(sbd_pkg::CFG_ITEM_COUNT, 32'd8);
        hold_cycles = 400;
        burst_left  = 60;
        send_draws(40);
    endtask

    task automatic test_random();
        int                              drawn;
        int                              target;
        int                              sent;
        int                              eff;
        logic                            d;
        logic [sbd_pkg::COUNT_CFG_W-1:0] count;
        logic [sbd_pkg::RNG_W-1:0]       seed;
        logic [sbd_pkg::RNG_W-1:0]       count_word;
        logic                            write_seed;
        drawn = 0;
        while (drawn < RANDOM_DRAWS)
        begin
            wait_idle();
            case ($urandom_range(0, 19))
                0:       count = 9'd0;
                1:       count = 9'd1;
                2:       count = 9'd256;
                3:       count = sbd_pkg::COUNT_CFG_W'($urandom_range(257, 511));
                default: count = sbd_pkg::COUNT_CFG_W'($urandom_range(2, 24));
            endcase
            if (phases_run == 2)
                count = 9'd256;
            write_seed = 1'b1;
            case ($urandom_range(0, 7))
                0:       seed = '0;
                1:       seed = '1;
                2:       write_seed = 1'b0;
                default: seed = $urandom;
            endcase
            count_word = {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, count};
            if ($urandom_range(0, 1))
            begin
                write_register(sbd_pkg::CFG_ITEM_COUNT, count_word);
                if (write_seed)
                    write_register(sbd_pkg::CFG_RNG_SEED, seed);
            end
            else
            begin
                if (write_seed)
                    write_register(sbd_pkg::CFG_RNG_SEED, seed);
                write_register(sbd_pkg::CFG_ITEM_COUNT, count_word);
            end
            eff = (count > BAG_DEPTH) ? BAG_DEPTH : int'(count);
            if (phases_run == 2)
                target = BAG_DEPTH;
            else if (eff > 64)
                target = $urandom_range(3, 12);
            else if (eff == 0)
                target = $urandom_range(2, 6);
            else
                target = $urandom_range(eff, (3 * eff > 60) ? 60 : 3 * eff);
            sent = 0;
            while (sent < target)
            begin
                d = ($urandom_range(0, 9) != 0);
                send_word(d);
                if (d)
                    sent++;
            end
            drawn += sent;
            phases_run++;
        end
    endtask

    // result side stall pattern
    initial
    begin
        rx_pattern_t rx_mode;
        int          rx_left;
        logic        rx_toggle;
        m_tready  = 1'b0;
        rx_mode   = RX_ALWAYS;
        rx_left   = 0;
        rx_toggle = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_pattern_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 96);
                end
                rx_left--;
                rx_toggle = ~rx_toggle;
                case (rx_mode)
                    RX_ALWAYS:    m_tready <= 1'b1;
                    RX_MOSTLY:    m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SELDOM:    m_tready <= ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: m_tready <= rx_toggle;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        draw_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser[0])
                empties_seen++;
            if (expected_draws.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result word, index %0d empty %0b",
                             $time, m_tdata, m_tuser[0]);
            end
            else
            begin
                want = expected_draws.pop_front();
                if (m_tdata !== want.index)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result %0d drawn_index expected %0d, got %0d",
                                 $time, results_seen, want.index, m_tdata);
                end
                if (m_tuser[0] !== want.empty)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result %0d bag_empty expected %0b, got %0b",
                                 $time, results_seen, want.empty, m_tuser[0]);
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_draws.size());
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        error_count  = 0;
        draws_sent   = 0;
        results_seen = 0;
        empties_seen = 0;
        reg_writes   = 0;
        phases_run   = 0;
        hold_cycles  = 0;
        count_reg    = '0;
        rng_state    = sbd_pkg::RNG_RESET;
        bag_pos      = '0;
        bag_built    = '0;
        new_burst();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_bag();
        test_first_shuffle();
        test_zero_seed();
        test_oversized_count();
        test_count_change();
        test_pressure();
        test_random();

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Run covered %0d draws (%0d empty) and %0d register writes,",
                 draws_sent, empties_seen, reg_writes);
        $display("over %0d random phases incl. a full 256-entry pass; %0d errors.",
                 phases_run, error_count);
        if (error_count == 0 && expected_draws.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sbd_pkg.sv
hw/rtl/sbd_rng.sv
hw/rtl/sbd_modulo.sv
hw/rtl/sbd_bag_mem.sv
hw/rtl/shuffle_bag_index_draw.sv
sim/testbench.sv
